// File: rtl/rpv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpv_pkg: shared types and constants for the running position variance block
// Sequencer states, arithmetic phases, the control bundle from sequencer to
// datapath, and the fixed variance width.
// ----------------------------------------------------------------------------
package rpv_pkg;

  // Variance word: 63-bit unsigned, saturating
  localparam int VAR_W = 63;
  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_SAVE,
    ST_DONE
  } rpv_state_t;

  // Arithmetic phases run on the shared unit
  typedef enum logic [2:0] {
    OP_NSQ,  // n * n
    OP_SQ,   // |d| * |d|
    OP_NV,   // n * var
    OP_TW,   // (d^2 + n*var) * (n - 1)
    OP_DV,   // previous product / n^2
    OP_MN    // |d| / n
  } rpv_op_t;

  // Control bundle from sequencer to datapath
  typedef struct packed {
    logic    idle;
    logic    load;
    logic    step;
    logic    save;
    logic    out_wr;
    logic    axis;
    rpv_op_t op;
  } rpv_ctrl_t;

endpackage

// File: rtl/rpv_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpv_unit: shared shift-add / shift-subtract unit
// One bit per step. Multiply: acc = 2*acc + (z msb ? opnd : 0), z shifts left.
// Divide (restoring): shift z msb into acc, subtract opnd when it fits, and
// shift the quotient bit into z lsb.
// ----------------------------------------------------------------------------
module rpv_unit #(
  parameter int AW = 128,
  parameter int OW = 96,
  parameter int ZW = 63
) (
  input  logic          clk,
  input  logic          load,
  input  logic          step,
  input  logic          div,
  input  logic [AW-1:0] acc_init,
  input  logic [OW-1:0] opnd_init,
  input  logic [ZW-1:0] z_init,
  output logic [AW-1:0] acc,
  output logic [ZW-1:0] z
);

  logic [OW-1:0] opnd;
  logic [AW:0]   a_op;
  logic [AW:0]   b_op;
  logic [AW:0]   b_in;
  logic [AW+1:0] sum;
  logic          qbit;
  logic [AW-1:0] acc_next;
  logic [ZW-1:0] z_next;

  // Single adder shared by both modes
  always_comb begin
    a_op = div ? {acc, z[ZW-1]} : {acc, 1'b0};
    b_op = (div || z[ZW-1]) ? (AW+1)'(opnd) : '0;
    b_in = div ? ~b_op : b_op;
    sum  = {1'b0, a_op} + {1'b0, b_in} + (AW+2)'(div);
    qbit = div & sum[AW+1];
    if (div) begin
      acc_next = qbit ? sum[AW-1:0] : a_op[AW-1:0];
    end else begin
      acc_next = sum[AW-1:0];
    end
    z_next = {z[ZW-2:0], qbit};
  end

  // Load operands or advance one bit
  always_ff @(posedge clk) begin
    if (load) begin
      acc  <= acc_init;
      opnd <= opnd_init;
      z    <= z_init;
    end else if (step) begin
      acc <= acc_next;
      z   <= z_next;
    end
  end

endmodule

// File: rtl/rpv_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpv_seq: sequencer for the shared arithmetic unit
// Walks n^2 once, then per axis: d^2, n*var, sum*(n-1), divide by n^2 and
// |d|/n, each as load, bit steps (none for a saturating divide) and a save.
// ----------------------------------------------------------------------------
module rpv_seq #(
  parameter int COUNT_WIDTH = 32,
  parameter int COORD_WIDTH = 40
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic skip,
  input  logic out_free,
  output rpv_pkg::rpv_ctrl_t ctrl
);
  import rpv_pkg::*;

  localparam int LEN_N   = COUNT_WIDTH;
  localparam int LEN_AD  = COORD_WIDTH + 1;
  localparam int LEN_M0  = (LEN_N > LEN_AD) ? LEN_N : LEN_AD;
  localparam int LEN_MAX = (LEN_M0 > VAR_W) ? LEN_M0 : VAR_W;
  localparam int CNT_W   = $clog2(LEN_MAX);

  rpv_state_t       state;
  rpv_state_t       state_next;
  rpv_op_t          op;
  rpv_op_t          op_next;
  logic             axis;
  logic             axis_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W-1:0] last;

  // Final step index of each phase
  function automatic logic [CNT_W-1:0] last_step(input rpv_op_t o);
    logic [CNT_W-1:0] r;
    unique case (o)
      OP_SQ, OP_MN: r = CNT_W'(LEN_AD - 1);
      OP_DV:        r = CNT_W'(VAR_W - 1);
      default:      r = CNT_W'(LEN_N - 1);
    endcase
    return r;
  endfunction

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_NSQ;
      axis  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      axis  <= axis_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and control outputs
  always_comb begin
    state_next  = state;
    op_next     = op;
    axis_next   = axis;
    cnt_next    = cnt;
    last        = last_step(op);
    ctrl        = '0;
    ctrl.op     = op;
    ctrl.axis   = axis;
    unique case (state)
      ST_IDLE: begin
        ctrl.idle = 1'b1;
        if (start) begin
          state_next = ST_LOAD;
          op_next    = OP_NSQ;
          axis_next  = 1'b0;
        end
      end
      ST_LOAD: begin
        ctrl.load = 1'b1;
        cnt_next  = '0;
        // saturating variance needs no division
        if (op == OP_DV && skip) begin
          state_next = ST_SAVE;
        end else begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        ctrl.step = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt == last) begin
          state_next = ST_SAVE;
        end
      end
      ST_SAVE: begin
        ctrl.save  = 1'b1;
        state_next = ST_LOAD;
        unique case (op)
          OP_NSQ: op_next = OP_SQ;
          OP_SQ:  op_next = OP_NV;
          OP_NV:  op_next = OP_TW;
          OP_TW:  op_next = OP_DV;
          OP_DV:  op_next = OP_MN;
          OP_MN: begin
            if (axis) begin
              state_next = ST_DONE;
            end else begin
              axis_next = 1'b1;
              op_next   = OP_SQ;
            end
          end
          default: op_next = OP_NSQ;
        endcase
      end
      ST_DONE: begin
        if (out_free) begin
          ctrl.out_wr = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/running_position_variance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_position_variance: running per-axis mean and population variance
// Relative planar positions, incremental mean and variance, one result per
// sample after the origin.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready) carries east_pos and north_pos in
//   1/256 m. The first transfer after reset becomes the origin and gives no
//   result; the block is ready again on the next cycle.
//   Every later transfer yields one result on the output channel
//   (out_valid/out_ready): both means, both variances and the sample count.
//   The result is written to the output register at the end of the
//   sequence, and the next input transfers only after that write, once
//   the sequencer is idle again: a sample is not taken while the last
//   one is still being worked on. The time is set by the single bit-serial
//   add/subtract unit that performs every multiply and divide; a saturating
//   variance skips its 63-step division on that axis.
//   in_ready is high only while the sequencer is idle.
//   The result sits in an output register: a stalled receiver does not hold
//   up the next sample's arithmetic, only the final write of its result.
//   Reset (rst, synchronous) clears origin, count, means and variances and
//   drops any pending result.
// ----------------------------------------------------------------------------
module running_position_variance #(
  parameter int COUNT_WIDTH = 32,
  parameter int COORD_WIDTH = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] east_pos,
  input  logic signed [COORD_WIDTH-1:0] north_pos,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] mean_east,
  output logic signed [COORD_WIDTH-1:0] mean_north,
  output logic [rpv_pkg::VAR_W-1:0]     var_east,
  output logic [rpv_pkg::VAR_W-1:0]     var_north,
  output logic [COUNT_WIDTH-1:0]        sample_count
);
  import rpv_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int NW    = COUNT_WIDTH;
  localparam int AD_W  = CW + 1;
  localparam int SQ_W  = 2 * CW + 2;
  localparam int NV_W  = NW + VAR_W;
  localparam int TS_W  = ((SQ_W > NV_W) ? SQ_W : NV_W) + 1;
  localparam int AW    = TS_W + NW;
  localparam int OW    = TS_W;
  localparam int ZW0   = (AD_W > VAR_W) ? AD_W : VAR_W;
  localparam int ZW    = (ZW0 > NW) ? ZW0 : NW;
  localparam int NSQ_W = 2 * NW;

  rpv_ctrl_t ctrl;

  // Sample state
  logic                 taken;
  logic [NW-1:0]        cnt;
  logic [NW-1:0]        cnt_inc;
  logic signed [CW-1:0] org_e;
  logic signed [CW-1:0] org_n;
  logic signed [CW-1:0] pos_e;
  logic signed [CW-1:0] pos_n;
  logic signed [CW-1:0] avg_e;
  logic signed [CW-1:0] avg_n;
  logic [VAR_W-1:0]     var_e;
  logic [VAR_W-1:0]     var_n;

  // Working registers
  logic [NSQ_W-1:0]     nsq;
  logic [TS_W-1:0]      tsum;
  logic [AD_W-1:0]      ad;
  logic                 dneg;
  logic                 ovf;

  // Unit connections
  logic [AW-1:0]        acc;
  logic [ZW-1:0]        z;
  logic [AW-1:0]        acc_init;
  logic [OW-1:0]        opnd_init;
  logic [ZW-1:0]        z_init;
  logic                 div;

  // Per-axis selection and offset
  logic signed [CW-1:0] pos_s;
  logic signed [CW-1:0] org_s;
  logic signed [CW-1:0] avg_s;
  logic [VAR_W-1:0]     var_s;
  logic signed [CW+1:0] d_val;
  logic [CW+1:0]        d_mag;
  logic                 d_neg;
  logic [AD_W-1:0]      ad_now;
  logic [AW-1:0]        acc_hi;
  logic                 ovf_now;
  logic [NW-1:0]        n_less;

  // Mean update
  logic signed [CW+1:0] step_x;
  logic signed [CW+1:0] mean_x;
  logic signed [CW-1:0] mean_sat;
  logic [VAR_W-1:0]     var_new;

  logic in_xfer;
  logic out_free;

  assign in_ready = ctrl.idle;
  assign in_xfer  = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;
  assign cnt_inc  = (&cnt) ? cnt : cnt + 1'b1;
  assign n_less   = cnt - 1'b1;
  assign div      = (ctrl.op == OP_DV) || (ctrl.op == OP_MN);

  rpv_seq #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (in_xfer & taken),
    .skip    (ovf_now),
    .out_free(out_free),
    .ctrl    (ctrl)
  );

  rpv_unit #(
    .AW(AW),
    .OW(OW),
    .ZW(ZW)
  ) u_unit (
    .clk      (clk),
    .load     (ctrl.load),
    .step     (ctrl.step),
    .div      (div),
    .acc_init (acc_init),
    .opnd_init(opnd_init),
    .z_init   (z_init),
    .acc      (acc),
    .z        (z)
  );

  // Select the axis and form the offset from the old mean
  always_comb begin
    pos_s  = ctrl.axis ? pos_n : pos_e;
    org_s  = ctrl.axis ? org_n : org_e;
    avg_s  = ctrl.axis ? avg_n : avg_e;
    var_s  = ctrl.axis ? var_n : var_e;
    d_val  = $signed({{2{pos_s[CW-1]}}, pos_s}) - $signed({{2{org_s[CW-1]}}, org_s})
           - $signed({{2{avg_s[CW-1]}}, avg_s});
    d_neg  = d_val[CW+1];
    d_mag  = d_neg ? -d_val : d_val;
    ad_now = d_mag[AD_W-1:0];
    acc_hi  = acc >> VAR_W;
    ovf_now = acc_hi >= AW'(nsq);
  end

  // Operand set for each phase
  always_comb begin
    acc_init  = '0;
    opnd_init = OW'(cnt);
    z_init    = ZW'(cnt) << (ZW - NW);
    unique case (ctrl.op)
      OP_NSQ: begin
        opnd_init = OW'(cnt);
        z_init    = ZW'(cnt) << (ZW - NW);
      end
      OP_SQ: begin
        opnd_init = OW'(ad_now);
        z_init    = ZW'(ad_now) << (ZW - AD_W);
      end
      OP_NV: begin
        opnd_init = OW'(var_s);
        z_init    = ZW'(cnt) << (ZW - NW);
      end
      OP_TW: begin
        opnd_init = tsum;
        z_init    = ZW'(n_less) << (ZW - NW);
      end
      OP_DV: begin
        acc_init  = acc_hi;
        opnd_init = OW'(nsq);
        z_init    = ZW'(acc[VAR_W-1:0]) << (ZW - VAR_W);
      end
      OP_MN: begin
        opnd_init = OW'(cnt);
        z_init    = ZW'(ad) << (ZW - AD_W);
      end
      default: begin
        acc_init = '0;
      end
    endcase
  end

  // New mean and variance, clamped
  always_comb begin
    step_x  = $signed({1'b0, z[AD_W-1:0]});
    mean_x  = $signed({{2{avg_s[CW-1]}}, avg_s}) + (dneg ? -step_x : step_x);
    if ((&mean_x[CW+1:CW-1]) || ~(|mean_x[CW+1:CW-1])) begin
      mean_sat = mean_x[CW-1:0];
    end else if (mean_x[CW+1]) begin
      mean_sat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      mean_sat = {1'b0, {(CW-1){1'b1}}};
    end
    var_new = ovf ? VAR_MAX : z[VAR_W-1:0];
  end

  // Transfer in, origin capture and count
  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= 1'b0;
      cnt   <= '0;
      org_e <= '0;
      org_n <= '0;
    end else if (in_xfer) begin
      if (!taken) begin
        taken <= 1'b1;
        cnt   <= cnt_inc;
        org_e <= east_pos;
        org_n <= north_pos;
      end else begin
        cnt <= (cnt_inc < NW'(2)) ? NW'(2) : cnt_inc;
      end
    end
  end

  // Hold the sample while it is worked on
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pos_e <= east_pos;
      pos_n <= north_pos;
    end
  end

  // Capture offset magnitude and overflow at phase load
  always_ff @(posedge clk) begin
    if (ctrl.load && ctrl.op == OP_SQ) begin
      ad   <= ad_now;
      dneg <= d_neg;
    end
    if (ctrl.load && ctrl.op == OP_DV) begin
      ovf <= ovf_now;
    end
  end

  // Save phase results
  always_ff @(posedge clk) begin
    if (ctrl.save) begin
      unique case (ctrl.op)
        OP_NSQ: nsq  <= acc[NSQ_W-1:0];
        OP_SQ:  tsum <= acc[TS_W-1:0];
        OP_NV:  tsum <= tsum + acc[TS_W-1:0];
        default: begin
          nsq <= nsq;
        end
      endcase
    end
  end

  // Update running statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_e <= '0;
      avg_n <= '0;
      var_e <= '0;
      var_n <= '0;
    end else if (ctrl.save) begin
      if (ctrl.op == OP_DV) begin
        if (ctrl.axis) begin
          var_n <= var_new;
        end else begin
          var_e <= var_new;
        end
      end
      if (ctrl.op == OP_MN) begin
        if (ctrl.axis) begin
          avg_n <= mean_sat;
        end else begin
          avg_e <= mean_sat;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_wr) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_wr) begin
      mean_east    <= avg_e;
      mean_north   <= avg_n;
      var_east     <= var_e;
      var_north    <= var_n;
      sample_count <= cnt;
    end
  end

endmodule

// File: verif/running_position_variance_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_position_variance_tb: self-checking bench for running mean/variance
// Feeds planar position fixes, with the first one taken as the origin, through
// the block. An in-bench predictor of the incremental mean and population
// variance checks every result, field by field, in order. The fixes cover
// small offsets about the origin, offsets wide enough to saturate the
// variance, and sample runs that push a mean into its clamp. Both channels
// idle at random, with a long receiver hold-off and full drains on the way.
// ----------------------------------------------------------------------------
module running_position_variance_tb;
  import rpv_pkg::*;

  localparam int COORD_W     = 40;
  localparam int COUNT_W     = 32;
  localparam int IDLE_PCT    = 38;
  localparam int N_RANDOM    = 1700;
  localparam int TAIL_CYCLES = 600;
  localparam int PRINT_CAP   = 30;

  localparam logic signed [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] POS_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] HOME_E  = 40'sd128000;

  typedef struct {
    logic signed [COORD_W-1:0] east;
    logic signed [COORD_W-1:0] north;
    bit                        drain;
  } fix_item_t;

  typedef struct {
    logic signed [COORD_W-1:0] mean_e;
    logic signed [COORD_W-1:0] mean_n;
    logic [VAR_W-1:0]          var_e;
    logic [VAR_W-1:0]          var_n;
    logic [COUNT_W-1:0]        count;
  } fix_stats_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] east_pos  = '0;
  logic signed [COORD_W-1:0] north_pos = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [COORD_W-1:0] mean_east;
  logic signed [COORD_W-1:0] mean_north;
  logic [VAR_W-1:0]          var_east;
  logic [VAR_W-1:0]          var_north;
  logic [COUNT_W-1:0]        sample_count;

  fix_item_t  pending_fixes[$];
  fix_stats_t stats_due[$];

  // Predictor state
  logic signed [COORD_W-1:0] origin_e   = '0;
  logic signed [COORD_W-1:0] origin_n   = '0;
  bit                        origin_set = 1'b0;
  logic [COUNT_W-1:0]        fix_count  = '0;
  logic signed [COORD_W-1:0] avg_e      = '0;
  logic signed [COORD_W-1:0] avg_n      = '0;
  logic [VAR_W-1:0]          spread_e   = '0;
  logic [VAR_W-1:0]          spread_n   = '0;

  int mismatches   = 0;
  int n_seen       = 0;
  int n_accepted   = 0;
  int tx_gap       = 0;
  int rx_hold      = 0;
  int rx_count     = 0;
  int n_var_sat    = 0;
  int n_mean_clamp = 0;

  running_position_variance #(
    .COUNT_WIDTH(COUNT_W),
    .COORD_WIDTH(COORD_W)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .east_pos    (east_pos),
    .north_pos   (north_pos),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mean_east   (mean_east),
    .mean_north  (mean_north),
    .var_east    (var_east),
    .var_north   (var_north),
    .sample_count(sample_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Advance one axis: exact truncating variance quotient, truncating mean step
  function automatic void advance_axis(input logic signed [COORD_W-1:0] pos,
                                       input logic signed [COORD_W-1:0] org,
                                       inout logic signed [COORD_W-1:0] avg,
                                       inout logic [VAR_W-1:0] spr,
                                       input logic [COUNT_W-1:0] n);
    longint       rel, dif, m;
    logic [63:0]  mag, step;
    logic [191:0] acc, nsq, quo;
    rel = longint'(pos) - longint'(org);
    dif = rel - longint'(avg);
    mag = (dif < 0) ? 64'(-dif) : 64'(dif);
    acc = 192'(mag) * 192'(mag) + 192'(n) * 192'(spr);
    acc = acc * 192'(n - 1'b1);
    nsq = 192'(n) * 192'(n);
    quo = acc / nsq;
    if (quo > 192'(VAR_MAX)) begin
      spr = VAR_MAX;
      n_var_sat++;
    end else begin
      spr = quo[VAR_W-1:0];
    end
    step = mag / 64'(n);
    m = (dif < 0) ? longint'(avg) - longint'(step) : longint'(avg) + longint'(step);
    if (m > longint'(POS_MAX)) begin
      m = longint'(POS_MAX);
      n_mean_clamp++;
    end else if (m < longint'(POS_MIN)) begin
      m = longint'(POS_MIN);
      n_mean_clamp++;
    end
    avg = m[COORD_W-1:0];
  endfunction

  // Take the origin, or update both axes and queue the statistics due
  function automatic void predict_fix(input logic signed [COORD_W-1:0] e,
                                      input logic signed [COORD_W-1:0] nn);
    fix_stats_t r;
    if (fix_count != '1) fix_count++;
    if (!origin_set) begin
      origin_e   = e;
      origin_n   = nn;
      origin_set = 1'b1;
      return;
    end
    if (fix_count < 2) fix_count = 2;
    advance_axis(e, origin_e, avg_e, spread_e, fix_count);
    advance_axis(nn, origin_n, avg_n, spread_n, fix_count);
    r.mean_e = avg_e;
    r.mean_n = avg_n;
    r.var_e  = spread_e;
    r.var_n  = spread_n;
    r.count  = fix_count;
    stats_due.push_back(r);
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("MISMATCH at result %0d, %s: got %h, want %h", n_seen, what, got, want);
  endtask

  task automatic add_fix(input logic signed [COORD_W-1:0] e,
                         input logic signed [COORD_W-1:0] nn, input bit drain);
    fix_item_t f;
    f.east  = e;
    f.north = nn;
    f.drain = drain;
    pending_fixes.push_back(f);
  endtask

  // Signed random offset of up to the given number of bits
  function automatic longint jitter(input int bits);
    logic [63:0] r;
    longint      v;
    r = {$urandom, $urandom};
    v = longint'(r & ((64'd1 << bits) - 1));
    return $urandom_range(1) ? v : -v;
  endfunction

  function automatic logic signed [COORD_W-1:0] any_pos();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[COORD_W-1:0];
  endfunction

  // Sender: offer queued fixes, idle at random, pause for a drain when marked
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      east_pos  <= '0;
      north_pos <= '0;
      tx_gap    = 0;
    end else begin
      if (in_valid && in_ready) begin
        void'(pending_fixes.pop_front());
        n_accepted++;
        if (!(n_accepted >= 300 && n_accepted < 500) && $urandom_range(99) < 8)
          tx_gap = $urandom_range(1, 600);
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_fixes.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_fixes[0].drain && n_seen != n_accepted - 1) begin
          in_valid <= 1'b0;
        end else if (!(n_accepted >= 300 && n_accepted < 500) &&
                     $urandom_range(99) < IDLE_PCT) begin
          in_valid <= 1'b0;
        end else begin
          in_valid  <= 1'b1;
          east_pos  <= pending_fixes[0].east;
          north_pos <= pending_fixes[0].north;
        end
      end
    end
  end

  // Receiver: random back-pressure, one long hold-off to fill the block
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold   = 0;
      rx_count  = 0;
    end else begin
      if (out_valid && out_ready) begin
        rx_count++;
        if (rx_count == 200) rx_hold = 3000;
        else if (!(rx_count >= 600 && rx_count < 800) && $urandom_range(99) < 8)
          rx_hold = $urandom_range(20, 600);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_count >= 600 && rx_count < 800) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Monitor: check each result transfer, then predict from each input transfer
  always @(posedge clk) begin : monitor
    fix_stats_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (stats_due.size() == 0) begin
          flag_mismatch("unexpected result", 64'(mean_east), '0);
        end else begin
          want = stats_due.pop_front();
          if (mean_east !== want.mean_e)
            flag_mismatch("mean_east", 64'(mean_east), 64'(want.mean_e));
          if (mean_north !== want.mean_n)
            flag_mismatch("mean_north", 64'(mean_north), 64'(want.mean_n));
          if (var_east !== want.var_e)
            flag_mismatch("var_east", 64'(var_east), 64'(want.var_e));
          if (var_north !== want.var_n)
            flag_mismatch("var_north", 64'(var_north), 64'(want.var_n));
          if (sample_count !== want.count)
            flag_mismatch("sample_count", 64'(sample_count), 64'(want.count));
        end
        n_seen <= n_seen + 1;
      end
      if (in_valid && in_ready) predict_fix(east_pos, north_pos);
    end
  end

  initial begin : stimulus
    int                        i, k, w;
    longint                    j;
    logic signed [COORD_W-1:0] e, nn;

    // Origin at a typical easting and the most negative northing, so the
    // northing offsets run wider than the coordinate range
    add_fix(HOME_E, POS_MIN, 1'b0);
    add_fix(HOME_E, POS_MIN, 1'b0);
    add_fix(HOME_E + 1, POS_MIN + 1, 1'b0);
    add_fix(HOME_E - 1, POS_MIN + 2, 1'b0);
    add_fix(HOME_E + 256, POS_MIN + 256, 1'b0);
    add_fix(HOME_E - 256, POS_MIN + 512, 1'b0);
    // Extremes: saturate the variance
    add_fix(POS_MAX, POS_MAX, 1'b0);
    add_fix(POS_MIN, POS_MIN, 1'b0);
    add_fix(POS_MAX, POS_MIN, 1'b0);
    add_fix(POS_MIN, POS_MAX, 1'b0);
    add_fix('0, '0, 1'b0);
    add_fix('1, '1, 1'b0);
    // Repeat the top position to drive the northing mean into its clamp
    for (i = 0; i < 10; i++) add_fix(POS_MAX, POS_MAX, 1'b0);
    add_fix(HOME_E, POS_MIN, 1'b1);

    // Random fixes: mostly jitter about the origin, some wide, some anywhere
    for (i = 0; i < N_RANDOM; i++) begin
      k = $urandom_range(99);
      if (k < 75) begin
        w  = (k < 55) ? $urandom_range(0, 20) : $urandom_range(21, 38);
        e  = COORD_W'(HOME_E + jitter(w));
        j  = jitter(w);
        nn = COORD_W'(POS_MIN + ((j < 0) ? -j : j));
      end else begin
        e  = any_pos();
        nn = any_pos();
      end
      add_fix(e, nn, (i == 700 || i == 1300));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait for every transfer in, every result out, then the block's latency
    while (pending_fixes.size() != 0 || in_valid) @(posedge clk);
    while (stats_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (stats_due.size() != 0) flag_mismatch("result never arrived", '0, '0);

    $display("Checked %0d results from %0d position fixes, origin included",
             n_seen, n_accepted);
    $display("Variance saturated %0d times and a mean clamped %0d times over both axes",
             n_var_sat, n_mean_clamp);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #60_000_000;
    $display("Timeout waiting for the block");
    $display("Regression FAIL");
    $finish;
  end

endmodule
